@@ src/bsc_pkg.sv @@
// bsc_pkg: shared types and constants for the brush segment clipper
// used by the divider, the top level and the checker
package bsc_pkg;

    localparam int ADDR_W = 5;
    localparam int SW     = 52;
    localparam int DW     = 54;

    localparam logic signed [31:0] ONE_Q     = 32'sd65536;
    localparam logic signed [31:0] NEG_ONE_Q = -32'sd65536;
    localparam logic signed [31:0] GROUND_Y  = 32'sd13107;
    localparam logic signed [31:0] EPSILON_Q = 32'sd6554;
    localparam logic signed [31:0] Q_MAX     = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN     = 32'sh80000000;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_END   = 2'd1,
        OP_BRUSH = 2'd2,
        OP_PLANE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_RAY    = 2'd0,
        MODE_BOX    = 2'd1,
        MODE_SPHERE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_RADIUS = 3'd1,
        REG_MIN_X  = 3'd2,
        REG_MIN_Y  = 3'd3,
        REG_MIN_Z  = 3'd4,
        REG_MAX_X  = 3'd5,
        REG_MAX_Y  = 3'd6,
        REG_MAX_Z  = 3'd7
    } t_reg;

    typedef struct packed {
        logic step;
        logic ladder;
        logic ground;
        logic stuck;
        logic coll;
    } t_tflags;

    typedef struct packed {
        logic rej;
        logic gout;
        logic sout;
        logic ladder;
        logic pass;
    } t_bflags;

    typedef struct packed {
        logic                 start;
        logic signed [DW-1:0] num;
        logic signed [DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;

endpackage

@@ src/bsc_if.sv @@
// bsc_in_if and bsc_res_if: valid/ready channels for item and result beats
// standalone, no package needed
interface bsc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] plane_offset;
    logic               pass_through;
    logic               ladder_flag;
    logic               last_side;

    modport source(output valid, opcode, coord_x, coord_y, coord_z, plane_offset,
                   pass_through, ladder_flag, last_side, input ready);
    modport sink(input valid, opcode, coord_x, coord_y, coord_z, plane_offset,
                 pass_through, ladder_flag, last_side, output ready);
endinterface

interface bsc_res_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] hit_ratio;
    logic               collided;
    logic               stuck;
    logic               on_ground;
    logic               at_ladder;
    logic               try_step;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;

    modport source(output valid, hit_ratio, collided, stuck, on_ground, at_ladder,
                   try_step, normal_x, normal_y, normal_z, input ready);
    modport sink(input valid, hit_ratio, collided, stuck, on_ground, at_ladder,
                 try_step, normal_x, normal_y, normal_z, output ready);
endinterface

@@ src/bsc_div.sv @@
// bsc_div: serial restoring divider giving a saturated signed Q16.16 ratio
// depends on bsc_pkg
module bsc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsc_pkg::t_div_req i_req,
    output bsc_pkg::t_div_rsp o_rsp
);
    import bsc_pkg::*;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHK,
        D_RUN
    } t_dstate;

    t_dstate         r_state;
    logic            r_neg;
    logic [DW-1:0]   r_na;
    logic [DW-1:0]   r_da;
    logic [DW-1:0]   r_rem;
    logic [30:0]     r_sh;
    logic [30:0]     r_q;
    logic [4:0]      r_cnt;
    logic            r_done;
    logic signed [31:0] r_quot;

    logic [DW:0]     n_r2;
    logic            n_bit;
    logic [30:0]     n_q;
    logic            n_sat;

    always_comb begin
        n_r2  = {r_rem, r_sh[30]};
        n_bit = (n_r2 >= {1'b0, r_da});
        n_q   = {r_q[29:0], n_bit};
        n_sat = ({15'd0, r_na} >= {r_da, 15'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_neg   <= i_req.num[DW-1] ^ i_req.den[DW-1];
                        r_na    <= i_req.num[DW-1] ? DW'(-i_req.num) : DW'(i_req.num);
                        r_da    <= i_req.den[DW-1] ? DW'(-i_req.den) : DW'(i_req.den);
                        r_state <= D_CHK;
                    end
                end
                D_CHK: begin
                    if (n_sat) begin
                        r_quot  <= r_neg ? Q_MIN : Q_MAX;
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_rem   <= r_na >> 15;
                        r_sh    <= {r_na[14:0], 16'd0};
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= n_bit ? DW'(n_r2 - {1'b0, r_da}) : DW'(n_r2);
                    r_sh  <= {r_sh[29:0], 1'b0};
                    r_q   <= n_q;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        r_quot  <= r_neg ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

@@ src/brush_segment_clip.sv @@
// brush_segment_clip: clips a ray, sphere or box segment against convex brushes
// depends on bsc_pkg, bsc_if and bsc_div
//
// Start, end and brush header beats are taken in S_IDLE, which stays ready
// for the next beat. A plane beat of a brush that is neither passed through
// nor rejected runs its dot products (start and end, plus the box corner in
// box mode) through one shared 32x32 multiplier, a multiply and an accumulate
// step per term: 6 terms for ray and sphere, 9 for box mode. A plane that
// straddles the surface then goes through the serial divider, one quotient
// bit per cycle, which skips its bit loop when the ratio saturates. The last
// plane posts the result beat from S_FIN. The input is not ready while a
// plane is at work; a result beat waits in its output register, and the next
// last plane holds the input until that beat is taken.
module brush_segment_clip (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bsc_in_if.sink                     i_in,
    bsc_res_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bsc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import bsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DECIDE,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;

    logic [1:0]         r_mode;
    logic [30:0]        r_radius;
    logic signed [31:0] r_bmin [3];
    logic signed [31:0] r_bmax [3];

    logic signed [31:0] r_start [3];
    logic signed [31:0] r_end [3];
    logic signed [17:0] r_best;
    t_tflags            r_tf;
    logic signed [31:0] r_cn [3];
    logic signed [31:0] r_enter;
    logic signed [31:0] r_exit;
    logic signed [31:0] r_bn [3];
    t_bflags            r_bf;

    logic signed [31:0] r_n [3];
    logic               r_last;
    logic signed [SW-1:0] r_sd;
    logic signed [SW-1:0] r_ed;
    logic signed [63:0] r_prod;
    logic [1:0]         r_axis;
    logic [1:0]         r_phase;
    logic               r_fwd;

    logic               r_ov;
    logic signed [17:0] r_o_best;
    t_tflags            r_o_tf;
    logic signed [31:0] r_o_cn [3];

    t_div_req           r_dreq;
    t_div_rsp           n_drsp;

    logic signed [31:0] n_a;
    logic signed [SW-1:0] n_m;
    logic signed [SW-1:0] n_init;
    logic signed [DW-1:0] n_sdx;
    logic signed [DW-1:0] n_edx;
    logic               n_sout;
    logic               n_gout;
    logic               n_moves;
    logic signed [17:0] n_best;
    t_tflags            n_tf;
    logic signed [31:0] n_cn [3];
    logic               n_cfg_wr;
    logic               n_out_free;

    bsc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_dreq),
        .o_rsp  (n_drsp)
    );

    always_comb begin
        case (r_phase)
            2'd0:    n_a = r_start[r_axis];
            2'd1:    n_a = r_end[r_axis];
            default: n_a = r_n[r_axis][31] ? r_bmax[r_axis] : r_bmin[r_axis];
        endcase
        n_m    = SW'($signed(r_prod[63:16]));
        n_init = SW'(i_in.plane_offset);
        if (r_mode == MODE_SPHERE) begin
            n_init = n_init + SW'({1'b0, r_radius});
        end
        n_sdx   = DW'(r_sd);
        n_edx   = DW'(r_ed);
        n_sout  = (r_sd > 0);
        n_gout  = (r_ed > 0);
        n_moves = (r_start[0] != r_end[0]) || (r_start[2] != r_end[2]);
    end

    // fold the finished brush into the trace
    always_comb begin
        n_best = r_best;
        n_tf   = r_tf;
        n_cn   = r_cn;
        if (!(r_bf.pass || r_bf.rej)) begin
            if (r_bf.ladder) begin
                n_tf.ladder = 1'b1;
            end
            if (!(r_bf.sout || r_bf.gout)) begin
                n_tf.stuck = 1'b1;
                n_tf.coll  = 1'b1;
                n_best     = '0;
                n_cn       = r_bn;
                if (r_bn[1] > GROUND_Y) begin
                    n_tf.ground = 1'b1;
                end
            end else if (r_enter < r_exit && r_enter > NEG_ONE_Q
                         && r_enter < 32'(r_best)) begin
                n_best    = r_enter[31] ? 18'sd0 : r_enter[17:0];
                n_tf.coll = 1'b1;
                n_cn      = r_bn;
                if (r_bn[1] > GROUND_Y) begin
                    n_tf.ground = 1'b1;
                end
            end
        end
    end

    assign n_cfg_wr   = psel && penable && pwrite;
    assign n_out_free = !r_ov || o_res.ready;

    always_comb begin
        case (t_reg'(paddr[4:2]))
            REG_MODE:   prdata = {30'd0, r_mode};
            REG_RADIUS: prdata = {1'b0, r_radius};
            REG_MIN_X:  prdata = r_bmin[0];
            REG_MIN_Y:  prdata = r_bmin[1];
            REG_MIN_Z:  prdata = r_bmin[2];
            REG_MAX_X:  prdata = r_bmax[0];
            REG_MAX_Y:  prdata = r_bmax[1];
            REG_MAX_Z:  prdata = r_bmax[2];
            default:    prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RAY;
            r_radius <= '0;
            r_bmin   <= '{default: '0};
            r_bmax   <= '{default: '0};
        end else if (n_cfg_wr) begin
            case (t_reg'(paddr[4:2]))
                REG_MODE:   r_mode   <= pwdata[1:0];
                REG_RADIUS: r_radius <= pwdata[30:0];
                REG_MIN_X:  r_bmin[0] <= pwdata;
                REG_MIN_Y:  r_bmin[1] <= pwdata;
                REG_MIN_Z:  r_bmin[2] <= pwdata;
                REG_MAX_X:  r_bmax[0] <= pwdata;
                REG_MAX_Y:  r_bmax[1] <= pwdata;
                REG_MAX_Z:  r_bmax[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= '{default: '0};
            r_end       <= '{default: '0};
            r_best      <= 18'(ONE_Q);
            r_tf        <= '0;
            r_cn        <= '{default: '0};
            r_enter     <= NEG_ONE_Q;
            r_exit      <= ONE_Q;
            r_bn        <= '{default: '0};
            r_bf        <= '0;
            r_ov        <= 1'b0;
            r_dreq.start <= 1'b0;
        end else begin
            r_dreq.start <= (r_state == S_DECIDE) && (n_sout != n_gout);
            if (r_state == S_FIN && n_out_free) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_n[0] <= i_in.coord_x;
                        r_n[1] <= i_in.coord_y;
                        r_n[2] <= i_in.coord_z;
                        r_last <= i_in.last_side;
                        case (t_op'(i_in.opcode))
                            OP_START: begin
                                r_start[0] <= i_in.coord_x;
                                r_start[1] <= i_in.coord_y;
                                r_start[2] <= i_in.coord_z;
                                r_best  <= 18'(ONE_Q);
                                r_tf    <= '0;
                                r_cn    <= '{default: '0};
                                r_enter <= NEG_ONE_Q;
                                r_exit  <= ONE_Q;
                                r_bn    <= '{default: '0};
                                r_bf    <= '0;
                            end
                            OP_END: begin
                                r_end[0] <= i_in.coord_x;
                                r_end[1] <= i_in.coord_y;
                                r_end[2] <= i_in.coord_z;
                            end
                            OP_BRUSH: begin
                                r_enter     <= NEG_ONE_Q;
                                r_exit      <= ONE_Q;
                                r_bn        <= '{default: '0};
                                r_bf        <= {3'b000, i_in.ladder_flag, i_in.pass_through};
                            end
                            OP_PLANE: begin
                                if (r_bf.pass || r_bf.rej) begin
                                    r_state <= i_in.last_side ? S_FIN : S_IDLE;
                                end else begin
                                    r_sd    <= n_init;
                                    r_ed    <= n_init;
                                    r_axis  <= '0;
                                    r_phase <= '0;
                                    r_state <= S_MUL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= n_a * r_n[r_axis];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_phase != 2'd1) begin
                        r_sd <= r_sd + n_m;
                    end
                    if (r_phase != 2'd0) begin
                        r_ed <= r_ed + n_m;
                    end
                    r_state <= S_MUL;
                    if (r_axis == 2'd2) begin
                        r_axis <= '0;
                        if (r_phase == 2'd0) begin
                            r_phase <= 2'd1;
                        end else if (r_phase == 2'd1 && r_mode == MODE_BOX) begin
                            r_phase <= 2'd2;
                        end else begin
                            r_state <= S_DECIDE;
                        end
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                S_DECIDE: begin
                    if (n_sout) begin
                        r_bf.sout <= 1'b1;
                    end
                    if (n_gout) begin
                        r_bf.gout <= 1'b1;
                    end
                    if (n_sout == n_gout) begin
                        if (n_sout) begin
                            r_bf.rej <= 1'b1;
                        end
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end else begin
                        r_fwd        <= (r_sd > r_ed);
                        r_dreq.num   <= (r_sd > r_ed) ? n_sdx - DW'(EPSILON_Q)
                                                      : n_sdx + DW'(EPSILON_Q);
                        r_dreq.den   <= n_sdx - n_edx;
                        r_state      <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (n_drsp.done) begin
                        if (r_fwd) begin
                            if (n_drsp.quot > r_enter) begin
                                r_enter <= n_drsp.quot;
                                r_bn    <= r_n;
                                if (n_moves && !r_n[1][31]) begin
                                    r_tf.step <= 1'b1;
                                end
                            end
                        end else if (n_drsp.quot < r_exit) begin
                            r_exit <= n_drsp.quot;
                        end
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end
                end
                S_FIN: begin
                    if (n_out_free) begin
                        r_best   <= n_best;
                        r_tf     <= n_tf;
                        r_cn     <= n_cn;
                        r_enter  <= NEG_ONE_Q;
                        r_exit   <= ONE_Q;
                        r_bn     <= '{default: '0};
                        r_bf     <= '0;
                        r_o_best <= n_best;
                        r_o_tf   <= n_tf;
                        r_o_cn   <= n_cn;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_res.valid     = r_ov;
    assign o_res.hit_ratio = r_o_best;
    assign o_res.collided  = r_o_tf.coll;
    assign o_res.stuck     = r_o_tf.stuck;
    assign o_res.on_ground = r_o_tf.ground;
    assign o_res.at_ladder = r_o_tf.ladder;
    assign o_res.try_step  = r_o_tf.step;
    assign o_res.normal_x  = r_o_cn[0];
    assign o_res.normal_y  = r_o_cn[1];
    assign o_res.normal_z  = r_o_cn[2];

endmodule

@@ src/bsc_chk.sv @@
// bsc_chk: port-level assertions for brush_segment_clip, bound to the top level
// depends on bsc_pkg
module bsc_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic [1:0]         i_opcode,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic signed [17:0] i_hit_ratio,
    input logic               i_collided,
    input logic               i_stuck
);
    import bsc_pkg::*;

    // a held result beat stays until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat dropped while stalled");

    // after a start, end or header beat the input is ready again in the next cycle
    a_short_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_opcode != OP_PLANE |=> i_in_ready)
        else $error("not ready after a one-cycle beat");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_hit_ratio[17] && i_hit_ratio <= 18'sd65536)
        else $error("hit ratio out of range");

    a_stuck_coll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_stuck |-> i_collided && i_hit_ratio == 18'sd0)
        else $error("stuck without collision at zero");

endmodule

bind brush_segment_clip bsc_chk u_bsc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_opcode   (i_in.opcode),
    .i_res_valid(o_res.valid),
    .i_res_ready(o_res.ready),
    .i_hit_ratio(o_res.hit_ratio),
    .i_collided (o_res.collided),
    .i_stuck    (o_res.stuck)
);
